// ===== rtl/cdoa_pkg.sv =====
// Package for the calendar date offset adder.
// Holds widths, divider biases, command/status structs and calendar helpers.
// No dependencies.
package cdoa_pkg;

  localparam int DvdW  = 22;  // divider dividend and quotient width
  localparam int RemW  = 9;   // divider remainder width, holds up to 399
  localparam int YearW = 18;  // working year and day-of-month width

  // Reciprocal divider: quotient is (dividend * recip) >> RcpShift
  localparam int RcpW     = 28;
  localparam int RcpShift = 31;
  localparam int QuoW     = DvdW + RcpW - RcpShift;

  // Divisors
  localparam logic [RemW-1:0] DivMin  = 9'd60;
  localparam logic [RemW-1:0] DivHour = 9'd24;
  localparam logic [RemW-1:0] DivLeap = 9'd400;
  localparam logic [RemW-1:0] DivMon  = 9'd12;

  // ceil(2^31 / divisor), exact for every dividend below 2^22
  localparam logic [RcpW-1:0] RecMin  = 28'd35791395;
  localparam logic [RcpW-1:0] RecHour = 28'd89478486;
  localparam logic [RcpW-1:0] RecLeap = 28'd5368710;
  localparam logic [RcpW-1:0] RecMon  = 28'd178956971;

  // Biases that keep every dividend positive; minute, hour and month biases:
  // divisor times a power of two, taken off the quotient for the floor carry.
  localparam logic [DvdW-1:0] MinBias  = 22'd1966080;  // 60 * 32768
  localparam logic [DvdW-1:0] HourBias = 22'd196608;   // 24 * 8192
  localparam logic [DvdW-1:0] YearBias = 22'd53100;    // 1900 + 400 * 128
  localparam logic [DvdW-1:0] MonBias  = 22'd6144;     // 12 * 512

  localparam logic signed [YearW-1:0] MinQOfs  = 18'sd32768;
  localparam logic signed [YearW-1:0] HourQOfs = 18'sd8192;
  localparam logic signed [YearW-1:0] MonQOfs  = 18'sd512;

  localparam logic [3:0] LastMonth = 4'd11;
  localparam logic [3:0] MonthsPerYear = 4'd12;
  localparam logic [RemW-1:0] LastR400 = 9'd399;

  typedef enum logic [1:0] {
    OP_MIN,
    OP_HOUR,
    OP_LEAP,
    OP_MON
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_RUN,
    ST_APPLY,
    ST_WALK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic apply;
    logic walk;
    logic emit;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic div_idle;
    logic walk_done;
  } status_t;

  // r is (year + 1900) mod 400
  function automatic logic is_leap(logic [RemW-1:0] r);
    return (r[1:0] == 2'd0) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
  endfunction

  function automatic logic [4:0] month_days(logic [3:0] mon, logic leap);
    logic [4:0] d;
    case (mon)
      4'd0:  d = 5'd31;
      4'd1:  d = leap ? 5'd29 : 5'd28;
      4'd2:  d = 5'd31;
      4'd3:  d = 5'd30;
      4'd4:  d = 5'd31;
      4'd5:  d = 5'd30;
      4'd6:  d = 5'd31;
      4'd7:  d = 5'd31;
      4'd8:  d = 5'd30;
      4'd9:  d = 5'd31;
      4'd10: d = 5'd30;
      4'd11: d = 5'd31;
      default: d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/cdoa_if.sv =====
// Valid/ready channel interfaces for the date offset adder.
// Depends on nothing; payload fields carry the item widths directly.
interface cdoa_in_if;
  logic               valid;
  logic               ready;
  logic [5:0]         minute_in;
  logic [4:0]         hour_in;
  logic [4:0]         day_in;
  logic [3:0]         month_in;
  logic signed [15:0] year_in;
  logic signed [20:0] delta_minutes;
  logic signed [16:0] delta_hours;
  logic signed [16:0] delta_days;
  logic signed [12:0] delta_months;
  logic signed [12:0] delta_years;

  modport source (output valid, minute_in, hour_in, day_in, month_in, year_in,
                  delta_minutes, delta_hours, delta_days, delta_months, delta_years,
                  input ready);
  modport sink (input valid, minute_in, hour_in, day_in, month_in, year_in,
                delta_minutes, delta_hours, delta_days, delta_months, delta_years,
                output ready);
endinterface

interface cdoa_out_if;
  logic               valid;
  logic               ready;
  logic [5:0]         minute_out;
  logic [4:0]         hour_out;
  logic [4:0]         day_out;
  logic [3:0]         month_out;
  logic signed [15:0] year_out;
  logic               year_overflow;

  modport source (output valid, minute_out, hour_out, day_out, month_out, year_out,
                  year_overflow, input ready);
  modport sink (input valid, minute_out, hour_out, day_out, month_out, year_out,
                year_overflow, output ready);
endinterface

// ===== rtl/calendar_date_offset_adder_top.sv =====
// Top level of the calendar date offset adder.
// Depends on cdoa_pkg, cdoa_if, cdoa_div, cdoa_datapath and cdoa_ctrl.
//
//   channel   modport             carries
//   operand   cdoa_in_if.sink     start date and signed deltas
//   result    cdoa_out_if.source  new date and year overflow flag
//
// One item at a time. An item runs four carry divisions, for the minute,
// hour and leap-cycle carries, then the day walk, one month per cycle, until
// the day fits its month, and last the month carry division; each division
// is a registered reciprocal multiply and a remainder step.
// rst is synchronous and clears the controller and divider control state.
// A stalled result waits in the output register while the next item is
// taken; the finished item holds in the datapath until that register frees.
module calendar_date_offset_adder_top
  import cdoa_pkg::*;
(
  input logic        clk,
  input logic        rst,
  cdoa_in_if.sink    operand,
  cdoa_out_if.source result
);

  cmd_t    cmd;
  status_t status;

  cdoa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (operand.valid),
    .in_ready  (operand.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd),
    .status    (status)
  );

  cdoa_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .minute_in     (operand.minute_in),
    .hour_in       (operand.hour_in),
    .day_in        (operand.day_in),
    .month_in      (operand.month_in),
    .year_in       (operand.year_in),
    .delta_minutes (operand.delta_minutes),
    .delta_hours   (operand.delta_hours),
    .delta_days    (operand.delta_days),
    .delta_months  (operand.delta_months),
    .delta_years   (operand.delta_years),
    .minute_out    (result.minute_out),
    .hour_out      (result.hour_out),
    .day_out       (result.day_out),
    .month_out     (result.month_out),
    .year_out      (result.year_out),
    .year_overflow (result.year_overflow)
  );

endmodule

// ===== rtl/cdoa_div.sv =====
// Constant divider by reciprocal multiplication: registered quotient multiply,
// then a back-multiply and subtract for the remainder. Depends on cdoa_pkg.
module cdoa_div
  import cdoa_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [DvdW-1:0] dividend,
  input  logic [RemW-1:0] divisor,
  input  logic [RcpW-1:0] recip,
  output logic [DvdW-1:0] quot,
  output logic [RemW-1:0] rem,
  output logic            idle
);

  logic [1:0]           steps;
  logic [DvdW-1:0]      dvd;
  logic [RemW-1:0]      dsr;
  logic [RcpW-1:0]      rcp;
  logic [DvdW+RcpW-1:0] prod;
  logic [QuoW-1:0]      q;
  logic [QuoW+RemW-1:0] back;

  assign prod = dvd * rcp;
  assign back = q * dsr;
  assign quot = {{(DvdW-QuoW){1'b0}}, q};
  assign idle = (steps == 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= 2'd0;
    end else if (start) begin
      steps <= 2'd2;
    end else if (steps != 2'd0) begin
      steps <= steps - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rcp <= recip;
    end
    if (steps == 2'd2) begin
      q <= prod[DvdW+RcpW-1:RcpShift];
    end
    if (steps == 2'd1) begin
      rem <= RemW'(dvd - back[DvdW-1:0]);
    end
  end

endmodule

// ===== rtl/cdoa_datapath.sv =====
// Datapath: date registers, carry division, month walk and result register.
// Depends on cdoa_pkg and cdoa_div.
module cdoa_datapath
  import cdoa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic [5:0]         minute_in,
  input  logic [4:0]         hour_in,
  input  logic [4:0]         day_in,
  input  logic [3:0]         month_in,
  input  logic signed [15:0] year_in,
  input  logic signed [20:0] delta_minutes,
  input  logic signed [16:0] delta_hours,
  input  logic signed [16:0] delta_days,
  input  logic signed [12:0] delta_months,
  input  logic signed [12:0] delta_years,
  output logic [5:0]         minute_out,
  output logic [4:0]         hour_out,
  output logic [4:0]         day_out,
  output logic [3:0]         month_out,
  output logic signed [15:0] year_out,
  output logic               year_overflow
);

  logic [5:0]              minute;
  logic [4:0]              hour;
  logic signed [YearW-1:0] mday;
  logic [3:0]              mon;
  logic signed [YearW-1:0] year;
  logic [RemW-1:0]         r400;
  logic signed [20:0]      dmin;
  logic signed [YearW-1:0] dhour;
  logic signed [YearW-1:0] dday;
  logic signed [12:0]      dmon;
  logic signed [12:0]      dyear;

  logic [DvdW-1:0]         dividend;
  logic [RemW-1:0]         divisor;
  logic [RcpW-1:0]         recip;
  logic [DvdW-1:0]         quot;
  logic [RemW-1:0]         rem;
  logic                    div_idle;
  logic signed [YearW-1:0] qs;

  logic [4:0]              dim_cur;
  logic [4:0]              dim_prev;
  logic [3:0]              pm, nm;
  logic [RemW-1:0]         pr, nr;
  logic signed [YearW-1:0] py, ny;
  logic                    below, above;

  cdoa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .recip    (recip),
    .quot     (quot),
    .rem      (rem),
    .idle     (div_idle)
  );

  // quotients stay below 2^17, so the top bit of this slice is zero
  assign qs = $signed(quot[YearW-1:0]);

  always_comb begin
    case (cmd.op)
      OP_MIN: begin
        dividend = {16'b0, minute} + {{1{dmin[20]}}, dmin} + MinBias;
        divisor  = DivMin;
        recip    = RecMin;
      end
      OP_HOUR: begin
        dividend = {17'b0, hour} + {{4{dhour[YearW-1]}}, dhour} + HourBias;
        divisor  = DivHour;
        recip    = RecHour;
      end
      OP_LEAP: begin
        dividend = {{4{year[YearW-1]}}, year} + YearBias;
        divisor  = DivLeap;
        recip    = RecLeap;
      end
      OP_MON: begin
        dividend = {18'b0, mon} + {{9{dmon[12]}}, dmon} + MonBias;
        divisor  = DivMon;
        recip    = RecMon;
      end
      default: begin
        dividend = '0;
        divisor  = DivMin;
        recip    = RecMin;
      end
    endcase
  end

  always_comb begin
    dim_cur = month_days(mon, is_leap(r400));
    if (mon == 4'd0) begin
      pm = LastMonth;
      py = year - 18'sd1;
      pr = (r400 == '0) ? LastR400 : r400 - 1'b1;
    end else begin
      pm = mon - 4'd1;
      py = year;
      pr = r400;
    end
    if (mon == LastMonth) begin
      nm = 4'd0;
      ny = year + 18'sd1;
      nr = (r400 == LastR400) ? '0 : r400 + 1'b1;
    end else begin
      nm = mon + 4'd1;
      ny = year;
      nr = r400;
    end
    dim_prev = month_days(pm, is_leap(pr));
    below    = mday[YearW-1] || (mday == '0);
    above    = !below && (mday > $signed({13'b0, dim_cur}));
  end

  assign status.div_idle  = div_idle;
  assign status.walk_done = !below && !above;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      minute <= minute_in;
      hour   <= hour_in;
      mday   <= {13'b0, day_in};
      dmin   <= delta_minutes;
      dhour  <= {{1{delta_hours[16]}}, delta_hours};
      dday   <= {{1{delta_days[16]}}, delta_days};
      dmon   <= delta_months;
      dyear  <= delta_years;
      // fold an out-of-range month into the year first
      if (month_in > LastMonth) begin
        mon  <= month_in - MonthsPerYear;
        year <= {{2{year_in[15]}}, year_in} + 18'sd1;
      end else begin
        mon  <= month_in;
        year <= {{2{year_in[15]}}, year_in};
      end
    end else if (cmd.apply) begin
      case (cmd.op)
        OP_MIN: begin
          minute <= rem[5:0];
          dhour  <= dhour + qs - MinQOfs;
        end
        OP_HOUR: begin
          hour <= rem[4:0];
          mday <= mday + dday + qs - HourQOfs;
        end
        OP_LEAP: begin
          r400 <= rem;
        end
        OP_MON: begin
          mon  <= rem[3:0];
          year <= year + {{5{dyear[12]}}, dyear} + qs - MonQOfs;
        end
        default: begin
        end
      endcase
    end else if (cmd.walk) begin
      if (below) begin
        mon  <= pm;
        year <= py;
        r400 <= pr;
        mday <= mday + $signed({13'b0, dim_prev});
      end else if (above) begin
        mon  <= nm;
        year <= ny;
        r400 <= nr;
        mday <= mday - $signed({13'b0, dim_cur});
      end
    end
  end

  // result register, frees the working registers for the next item
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      minute_out    <= minute;
      hour_out      <= hour;
      day_out       <= mday[4:0];
      month_out     <= mon;
      year_out      <= year[15:0];
      year_overflow <= (year[YearW-1:15] != '0) && (year[YearW-1:15] != '1);
    end
  end

endmodule

// ===== rtl/cdoa_ctrl.sv =====
// Controller: sequences load, four carry divisions, month walk and hand-off.
// Depends on cdoa_pkg.
module cdoa_ctrl
  import cdoa_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output cmd_t    cmd,
  input  status_t status
);

  state_t state, state_next;
  op_t    op, op_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      op        <= OP_MIN;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      op        <= op_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next    = state;
    op_next       = op;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.op        = op;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          op_next    = OP_MIN;
          state_next = ST_START;
        end
      end
      ST_START: begin
        cmd.div_start = 1'b1;
        state_next    = ST_RUN;
      end
      ST_RUN: begin
        if (status.div_idle) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd.apply = 1'b1;
        case (op)
          OP_MIN: begin
            op_next    = OP_HOUR;
            state_next = ST_START;
          end
          OP_HOUR: begin
            op_next    = OP_LEAP;
            state_next = ST_START;
          end
          OP_LEAP: begin
            state_next = ST_WALK;
          end
          OP_MON: begin
            state_next = ST_DONE;
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end
      ST_WALK: begin
        // step one month per cycle until the day fits
        cmd.walk = 1'b1;
        if (status.walk_done) begin
          op_next    = OP_MON;
          state_next = ST_START;
        end
      end
      ST_DONE: begin
        // hold until the result register is free
        if (!out_valid || out_ready) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule
